// File: sv/clpm_pkg.sv
`default_nettype none

package clpm_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam logic [15:0] HASH_MUL = 16'd1037;

    localparam logic [7:0] MUL_STEPS   = 8'd16;
    localparam logic [7:0] DIV16_STEPS = 8'd16;
    localparam logic [7:0] DIV17_STEPS = 8'd17;
    localparam logic [7:0] HASH_STEPS  = 8'd27;
    localparam logic [7:0] DIV32_STEPS = 8'd32;

    localparam logic [1:0] REG_NUM_STATES    = 2'd0;
    localparam logic [1:0] REG_NUM_PES       = 2'd1;
    localparam logic [1:0] REG_PES_PER_GROUP = 2'd2;
    localparam logic [1:0] REG_NUM_PLANES    = 2'd3;

    localparam logic [1:0] STATUS_NORMAL    = 2'd0;
    localparam logic [1:0] STATUS_HASH      = 2'd1;
    localparam logic [1:0] STATUS_ZERO_LOAD = 2'd2;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic       start;
        alu_op_t    op;
        logic [7:0] nbits;
    } alu_cmd_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LD_RD,
        ST_LD_UPD,
        ST_H_MUL,
        ST_H_DIV,
        ST_GROUPS,
        ST_PART,
        ST_GRP,
        ST_START_MUL,
        ST_START_MOD,
        ST_WALK,
        ST_WALK_DRAIN,
        ST_CUM_MUL,
        ST_OFF_MUL,
        ST_NP_MUL,
        ST_DEN_MUL,
        ST_Q_DIV,
        ST_QMOD,
        ST_FINAL,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// File: sv/clpm_alu.sv
`default_nettype none

module clpm_alu #(
    parameter int DW = 56
) (
    input  logic                clk,
    input  logic                rst_n,
    input  clpm_pkg::alu_cmd_t  cmd,
    input  logic [DW-1:0]       op_a,
    input  logic [DW-1:0]       op_b,
    output logic                done,
    output logic [DW-1:0]       acc,
    output logic [DW-1:0]       quo
);

    localparam int CW = $clog2(DW + 1);
    localparam int IW = $clog2(DW);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    clpm_pkg::alu_op_t   op_reg, op_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [DW-1:0]       acc_reg, acc_next;
    logic [DW-1:0]       a_reg, a_next;
    logic [DW-1:0]       b_reg, b_next;
    logic [DW-1:0]       q_reg, q_next;

    logic [CW-1:0]       cnt_dec;
    logic                div_bit;
    logic [DW:0]         trial;
    logic [DW:0]         diff;
    logic                fits;

    assign cnt_dec = cnt_reg - CW'(1);
    assign div_bit = a_reg[cnt_dec[IW-1:0]];
    assign trial   = {acc_reg, div_bit};
    assign diff    = trial - {1'b0, b_reg};
    assign fits    = trial >= {1'b0, b_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        q_next    = q_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            op_next   = cmd.op;
            cnt_next  = CW'(cmd.nbits);
            acc_next  = '0;
            a_next    = op_a;
            b_next    = op_b;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            case (op_reg)
                clpm_pkg::ALU_MUL:
                begin
                    if (b_reg[0])
                    begin
                        acc_next = acc_reg + a_reg;
                    end
                    a_next = a_reg << 1;
                    b_next = b_reg >> 1;
                end
                clpm_pkg::ALU_DIV:
                begin
                    acc_next = fits ? diff[DW-1:0] : trial[DW-1:0];
                    q_next   = {q_reg[DW-2:0], fits};
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
            cnt_next = cnt_dec;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= clpm_pkg::ALU_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign acc  = acc_reg;
    assign quo  = q_reg;

endmodule

`default_nettype wire

// File: sv/cumulative_load_plane_mapper.sv
`default_nettype none

// Places a (state, plane) object on a processor from a table of plane weights. After reset
// the block zeroes the weight table, one entry a cycle, and accepts no transaction meanwhile;
// configuration writes are taken at any time the block is idle. Every multiplication and
// division runs on one shared shift-add multiplier / restoring divider that retires one bit
// a cycle. A query with a plane outside the planes in use is hashed, and a query that finds
// zero total load skips the table walk; any other query runs twelve unit operations, among
// them the quotient of the cumulative load over DW = WEIGHT_BITS + clog2(TABLE_DEPTH) + 32
// bits, and one table read per plane up to and including the queried one. One transaction
// is worked at a time; a finished result sits in the output register while the next
// transaction starts, and a query waits at its end while that register is still full.
module cumulative_load_plane_mapper #(
    parameter int TABLE_DEPTH = clpm_pkg::TABLE_DEPTH_DEF,
    parameter int WEIGHT_BITS = clpm_pkg::WEIGHT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [15:0] state_index,
    input  logic [15:0] plane_index,
    input  logic [15:0] weight,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] pe,
    output logic [1:0]  status
);

    localparam int AW         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int TOTAL_BITS = WEIGHT_BITS + $clog2(TABLE_DEPTH);
    localparam int DW         = TOTAL_BITS + 32;

    logic [15:0] num_states_reg;
    logic [15:0] num_pes_reg;
    logic [15:0] ppg_reg;
    logic [8:0]  num_planes_reg;
    logic        cfg_wr;

    logic [15:0] ns;
    logic [15:0] np;
    logic [15:0] ppg;

    clpm_pkg::state_t state_reg, state_next;
    logic             issued_reg, issued_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             rd_last_reg, rd_last_next;
    logic             out_valid_reg, out_valid_next;
    logic [TOTAL_BITS-1:0] total_reg, total_next;

    logic [15:0]            s_reg, s_next;
    logic [15:0]            p_reg, p_next;
    logic [WEIGHT_BITS-1:0] w_reg, w_next;
    logic [15:0]            groups_reg, groups_next;
    logic [15:0]            part_reg, part_next;
    logic [15:0]            off_reg, off_next;
    logic [15:0]            grp_reg, grp_next;
    logic [31:0]            start_reg, start_next;
    logic [15:0]            smod_reg, smod_next;
    logic [15:0]            t_reg, t_next;
    logic [TOTAL_BITS-1:0]  sum_reg, sum_next;
    logic [WEIGHT_BITS-1:0] wp_reg, wp_next;
    logic [DW-1:0]          num_reg, num_next;
    logic [DW-1:0]          den_reg, den_next;
    logic [15:0]            res_pe_reg, res_pe_next;
    logic [1:0]             res_status_reg, res_status_next;
    logic [15:0]            pe_reg, pe_next;
    logic [1:0]             status_reg, status_next;

    logic [WEIGHT_BITS-1:0] mem [TABLE_DEPTH];
    logic [WEIGHT_BITS-1:0] mem_rdata_reg;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [WEIGHT_BITS-1:0] mem_wdata;
    logic [AW-1:0]          mem_raddr;

    clpm_pkg::alu_cmd_t alu_cmd;
    logic [DW-1:0]      alu_a;
    logic [DW-1:0]      alu_b;
    logic               alu_done;
    logic [DW-1:0]      alu_acc;
    logic [DW-1:0]      alu_quo;
    logic               alu_fin;
    logic               use_alu;

    logic plane_in_table;
    logic plane_in_use;

    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_states_reg <= 16'd1;
            num_pes_reg    <= 16'd1;
            ppg_reg        <= 16'd1;
            num_planes_reg <= 9'd1;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                clpm_pkg::REG_NUM_STATES:    num_states_reg <= pwdata[15:0];
                clpm_pkg::REG_NUM_PES:       num_pes_reg    <= pwdata[15:0];
                clpm_pkg::REG_PES_PER_GROUP: ppg_reg        <= pwdata[15:0];
                clpm_pkg::REG_NUM_PLANES:    num_planes_reg <= pwdata[8:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            clpm_pkg::REG_NUM_STATES:    prdata = {16'd0, num_states_reg};
            clpm_pkg::REG_NUM_PES:       prdata = {16'd0, num_pes_reg};
            clpm_pkg::REG_PES_PER_GROUP: prdata = {16'd0, ppg_reg};
            clpm_pkg::REG_NUM_PLANES:    prdata = {23'd0, num_planes_reg};
        endcase
    end

    assign ns  = (num_states_reg == 16'd0) ? 16'd1 : num_states_reg;
    assign np  = (num_pes_reg == 16'd0) ? 16'd1 : num_pes_reg;
    assign ppg = (ppg_reg == 16'd0) ? 16'd1 : ppg_reg;

    assign plane_in_table = plane_index < 16'(TABLE_DEPTH);
    assign plane_in_use   = plane_in_table && (plane_index < {7'd0, num_planes_reg});

    clpm_alu #(
        .DW (DW)
    ) u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (alu_cmd),
        .op_a  (alu_a),
        .op_b  (alu_b),
        .done  (alu_done),
        .acc   (alu_acc),
        .quo   (alu_quo)
    );

    assign alu_fin = issued_reg & alu_done;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        rd_pend_next    = 1'b0;
        rd_last_next    = rd_last_reg;
        out_valid_next  = out_valid_reg & ~out_ready;
        total_next      = total_reg;
        s_next          = s_reg;
        p_next          = p_reg;
        w_next          = w_reg;
        groups_next     = groups_reg;
        part_next       = part_reg;
        off_next        = off_reg;
        grp_next        = grp_reg;
        start_next      = start_reg;
        smod_next       = smod_reg;
        t_next          = t_reg;
        sum_next        = sum_reg;
        wp_next         = wp_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        res_pe_next     = res_pe_reg;
        res_status_next = res_status_reg;
        pe_next         = pe_reg;
        status_next     = status_reg;
        alu_cmd         = '{start: 1'b0, op: clpm_pkg::ALU_MUL, nbits: 8'd0};
        alu_a           = '0;
        alu_b           = '0;
        use_alu         = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = '0;
        mem_raddr       = idx_reg;

        // consume table data for the prefix walk
        if (rd_pend_reg)
        begin
            if (rd_last_reg)
            begin
                wp_next = mem_rdata_reg;
            end
            else
            begin
                sum_next = sum_reg + TOTAL_BITS'(mem_rdata_reg);
            end
        end

        unique case (state_reg)
            clpm_pkg::ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (idx_reg == AW'(TABLE_DEPTH - 1))
                begin
                    idx_next   = '0;
                    state_next = clpm_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            clpm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    s_next = state_index;
                    p_next = plane_index;
                    w_next = WEIGHT_BITS'(weight);
                    if (req_type == clpm_pkg::REQ_LOAD)
                    begin
                        if (plane_in_table)
                        begin
                            state_next = clpm_pkg::ST_LD_RD;
                        end
                    end
                    else if (plane_in_use)
                    begin
                        state_next = clpm_pkg::ST_GROUPS;
                    end
                    else
                    begin
                        state_next = clpm_pkg::ST_H_MUL;
                    end
                end
            end
            clpm_pkg::ST_LD_RD:
            begin
                mem_raddr  = p_reg[AW-1:0];
                state_next = clpm_pkg::ST_LD_UPD;
            end
            clpm_pkg::ST_LD_UPD:
            begin
                mem_we     = 1'b1;
                mem_waddr  = p_reg[AW-1:0];
                mem_wdata  = w_reg;
                total_next = total_reg - TOTAL_BITS'(mem_rdata_reg) + TOTAL_BITS'(w_reg);
                state_next = clpm_pkg::ST_IDLE;
            end
            clpm_pkg::ST_H_MUL:
            begin
                use_alu       = 1'b1;
                alu_cmd.op    = clpm_pkg::ALU_MUL;
                alu_cmd.nbits = clpm_pkg::MUL_STEPS;
                alu_a         = DW'(s_reg);
                alu_b         = DW'(clpm_pkg::HASH_MUL);
                if (alu_fin)
                begin
                    num_next   = alu_acc + DW'(p_reg);
                    state_next = clpm_pkg::ST_H_DIV;
                end
            end
            clpm_pkg::ST_H_DIV:
            begin
                use_alu       = 1'b1;
                alu_cmd.op    = clpm_pkg::ALU_DIV;
                alu_cmd.nbits = clpm_pkg::HASH_STEPS;
                alu_a         = num_reg;
                alu_b         = DW'(np);
                if (alu_fin)
                begin
                    res_pe_next     = alu_acc[15:0];
                    res_status_next = clpm_pkg::STATUS_HASH;
                    state_next      = clpm_pkg::ST_OUT;
                end
            end
            clpm_pkg::ST_GROUPS:
            begin
                use_alu       = 1'b1;
                alu_cmd.op    = clpm_pkg::ALU_DIV;
                alu_cmd.nbits = clpm_pkg::DIV16_STEPS;
                alu_a         = DW'(np);
                alu_b         = DW'(ppg);
                if (alu_fin)
                begin
                    groups_next = (alu_quo[15:0] == 16'd0) ? 16'd1 : alu_quo[15:0];
                    state_next  = clpm_pkg::ST_PART;
                end
            end
            clpm_pkg::ST_PART:
            begin
                use_alu       = 1'b1;
                alu_cmd.op    = clpm_pkg::ALU_DIV;
                alu_cmd.nbits = clpm_pkg::DIV17_STEPS;
                alu_a         = DW'({1'b0, ns} + {1'b0, groups_reg} - 17'd1);
                alu_b         = DW'(groups_reg);
                if (alu_fin)
                begin
                    part_next  = alu_quo[15:0];
                    state_next = clpm_pkg::ST_GRP;
                end
            end
            clpm_pkg::ST_GRP:
            begin
                use_alu       = 1'b1;
                alu_cmd.op    = clpm_pkg::ALU_DIV;
                alu_cmd.nbits = clpm_pkg::DIV16_STEPS;
                alu_a         = DW'(s_reg);
                alu_b         = DW'(part_reg);
                if (alu_fin)
                begin
                    grp_next   = alu_quo[15:0];
                    off_next   = alu_acc[15:0] + 16'd1;
                    state_next = clpm_pkg::ST_START_MUL;
                end
            end
            clpm_pkg::ST_START_MUL:
            begin
                use_alu       = 1'b1;
                alu_cmd.op    = clpm_pkg::ALU_MUL;
                alu_cmd.nbits = clpm_pkg::MUL_STEPS;
                alu_a         = DW'(grp_reg);
                alu_b         = DW'(ppg);
                if (alu_fin)
                begin
                    start_next = alu_acc[31:0];
                    state_next = clpm_pkg::ST_START_MOD;
                end
            end
            clpm_pkg::ST_START_MOD:
            begin
                use_alu       = 1'b1;
                alu_cmd.op    = clpm_pkg::ALU_DIV;
                alu_cmd.nbits = clpm_pkg::DIV32_STEPS;
                alu_a         = DW'(start_reg);
                alu_b         = DW'(np);
                if (alu_fin)
                begin
                    smod_next = alu_acc[15:0];
                    if (total_reg == '0)
                    begin
                        res_pe_next     = alu_acc[15:0];
                        res_status_next = clpm_pkg::STATUS_ZERO_LOAD;
                        state_next      = clpm_pkg::ST_OUT;
                    end
                    else
                    begin
                        sum_next   = '0;
                        idx_next   = '0;
                        state_next = clpm_pkg::ST_WALK;
                    end
                end
            end
            clpm_pkg::ST_WALK:
            begin
                mem_raddr    = idx_reg;
                rd_pend_next = 1'b1;
                rd_last_next = (idx_reg == p_reg[AW-1:0]);
                if (idx_reg == p_reg[AW-1:0])
                begin
                    state_next = clpm_pkg::ST_WALK_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            clpm_pkg::ST_WALK_DRAIN:
            begin
                idx_next   = '0;
                state_next = clpm_pkg::ST_CUM_MUL;
            end
            clpm_pkg::ST_CUM_MUL:
            begin
                use_alu       = 1'b1;
                alu_cmd.op    = clpm_pkg::ALU_MUL;
                alu_cmd.nbits = clpm_pkg::MUL_STEPS;
                alu_a         = DW'(sum_reg);
                alu_b         = DW'(part_reg);
                if (alu_fin)
                begin
                    num_next   = alu_acc;
                    state_next = clpm_pkg::ST_OFF_MUL;
                end
            end
            clpm_pkg::ST_OFF_MUL:
            begin
                use_alu       = 1'b1;
                alu_cmd.op    = clpm_pkg::ALU_MUL;
                alu_cmd.nbits = clpm_pkg::MUL_STEPS;
                alu_a         = DW'(wp_reg);
                alu_b         = DW'(off_reg);
                if (alu_fin)
                begin
                    num_next   = num_reg + alu_acc;
                    state_next = clpm_pkg::ST_NP_MUL;
                end
            end
            clpm_pkg::ST_NP_MUL:
            begin
                use_alu       = 1'b1;
                alu_cmd.op    = clpm_pkg::ALU_MUL;
                alu_cmd.nbits = clpm_pkg::MUL_STEPS;
                alu_a         = num_reg;
                alu_b         = DW'(np);
                if (alu_fin)
                begin
                    num_next   = alu_acc;
                    state_next = clpm_pkg::ST_DEN_MUL;
                end
            end
            clpm_pkg::ST_DEN_MUL:
            begin
                use_alu       = 1'b1;
                alu_cmd.op    = clpm_pkg::ALU_MUL;
                alu_cmd.nbits = clpm_pkg::MUL_STEPS;
                alu_a         = DW'(total_reg);
                alu_b         = DW'(ns);
                if (alu_fin)
                begin
                    den_next   = alu_acc;
                    state_next = clpm_pkg::ST_Q_DIV;
                end
            end
            clpm_pkg::ST_Q_DIV:
            begin
                use_alu       = 1'b1;
                alu_cmd.op    = clpm_pkg::ALU_DIV;
                alu_cmd.nbits = 8'(DW);
                alu_a         = num_reg;
                alu_b         = den_reg;
                if (alu_fin)
                begin
                    t_next     = alu_quo[15:0];
                    state_next = clpm_pkg::ST_QMOD;
                end
            end
            clpm_pkg::ST_QMOD:
            begin
                use_alu       = 1'b1;
                alu_cmd.op    = clpm_pkg::ALU_DIV;
                alu_cmd.nbits = clpm_pkg::DIV16_STEPS;
                alu_a         = DW'(t_reg);
                alu_b         = DW'(ppg);
                if (alu_fin)
                begin
                    t_next     = alu_acc[15:0];
                    state_next = clpm_pkg::ST_FINAL;
                end
            end
            clpm_pkg::ST_FINAL:
            begin
                use_alu       = 1'b1;
                alu_cmd.op    = clpm_pkg::ALU_DIV;
                alu_cmd.nbits = clpm_pkg::DIV17_STEPS;
                alu_a         = DW'({1'b0, t_reg} + {1'b0, smod_reg});
                alu_b         = DW'(np);
                if (alu_fin)
                begin
                    res_pe_next     = alu_acc[15:0];
                    res_status_next = clpm_pkg::STATUS_NORMAL;
                    state_next      = clpm_pkg::ST_OUT;
                end
            end
            clpm_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    pe_next        = res_pe_reg;
                    status_next    = res_status_reg;
                    state_next     = clpm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = clpm_pkg::ST_IDLE;
            end
        endcase

        // start the unit once per state, advance when it reports done
        alu_cmd.start = use_alu & ~issued_reg;
        issued_next   = use_alu & ~alu_fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= clpm_pkg::ST_CLEAR;
            issued_reg    <= 1'b0;
            idx_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            rd_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            idx_reg       <= idx_next;
            rd_pend_reg   <= rd_pend_next;
            rd_last_reg   <= rd_last_next;
            out_valid_reg <= out_valid_next;
            total_reg     <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg          <= s_next;
        p_reg          <= p_next;
        w_reg          <= w_next;
        groups_reg     <= groups_next;
        part_reg       <= part_next;
        off_reg        <= off_next;
        grp_reg        <= grp_next;
        start_reg      <= start_next;
        smod_reg       <= smod_next;
        t_reg          <= t_next;
        sum_reg        <= sum_next;
        wp_reg         <= wp_next;
        num_reg        <= num_next;
        den_reg        <= den_next;
        res_pe_reg     <= res_pe_next;
        res_status_reg <= res_status_next;
        pe_reg         <= pe_next;
        status_reg     <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    assign in_ready  = (state_reg == clpm_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign pe        = pe_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

// File: test/placement_checker.sv
`timescale 1ns / 100ps

module placement_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        req_type,
    input  logic [15:0] state_index,
    input  logic [15:0] plane_index,
    input  logic [15:0] weight,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] pe,
    input  logic [1:0]  status,
    output int          open_queries,
    output int          mismatches
);

    localparam int TABLE_DEPTH = clpm_pkg::TABLE_DEPTH_DEF;

    typedef struct packed {
        logic [15:0] pe;
        logic [1:0]  status;
    } placement_t;

    logic [15:0] plane_load [TABLE_DEPTH];
    logic [23:0] weight_total;
    logic [15:0] states_cfg;
    logic [15:0] pes_cfg;
    logic [15:0] group_cfg;
    logic [8:0]  planes_cfg;
    placement_t  pending_placements [$];
    int          fail_tally;

    function automatic placement_t place_object(input logic [15:0] s, input logic [15:0] p);
        logic [63:0] ns;
        logic [63:0] np;
        logic [63:0] ppg;
        logic [63:0] used;
        logic [63:0] groups;
        logic [63:0] part;
        logic [63:0] grp;
        logic [63:0] base_pe;
        logic [63:0] cum;
        logic [63:0] quot;
        placement_t  res;
        int          x;
        ns = (states_cfg == 16'd0) ? 64'd1 : 64'(states_cfg);
        np = (pes_cfg == 16'd0) ? 64'd1 : 64'(pes_cfg);
        ppg = (group_cfg == 16'd0) ? 64'd1 : 64'(group_cfg);
        used = (planes_cfg < TABLE_DEPTH) ? 64'(planes_cfg) : 64'(TABLE_DEPTH);
        if (64'(p) >= used)
        begin
            res.pe = 16'((64'(s) * 64'(clpm_pkg::HASH_MUL) + 64'(p)) % np);
            res.status = clpm_pkg::STATUS_HASH;
            return res;
        end
        groups = np / ppg;
        if (groups == 64'd0)
            groups = 64'd1;
        part = (ns + groups - 64'd1) / groups;
        grp = 64'(s) / part;
        base_pe = grp * ppg;
        if (weight_total == 24'd0)
        begin
            res.pe = 16'(base_pe % np);
            res.status = clpm_pkg::STATUS_ZERO_LOAD;
            return res;
        end
        cum = 64'd0;
        for (x = 0; x < int'(p); x++)
            cum += 64'(plane_load[x]) * part;
        cum += (64'(s) - grp * part + 64'd1) * 64'(plane_load[p[7:0]]);
        quot = (cum * np) / (64'(weight_total) * ns);
        res.pe = 16'(((quot % ppg) + base_pe) % np);
        res.status = clpm_pkg::STATUS_NORMAL;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        placement_t want;
        int         i;
        if (!rst_n)
        begin
            for (i = 0; i < TABLE_DEPTH; i++)
                plane_load[i] = 16'd0;
            weight_total = 24'd0;
            states_cfg = 16'd1;
            pes_cfg = 16'd1;
            group_cfg = 16'd1;
            planes_cfg = 9'd1;
            pending_placements.delete();
            fail_tally = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_placements.size() == 0)
                begin
                    $error("result with no pending query: pe %0d, status %0d", pe, status);
                    fail_tally++;
                end
                else
                begin
                    want = pending_placements.pop_front();
                    if (pe !== want.pe)
                    begin
                        $error("pe mismatch: expected %0d, actual %0d", want.pe, pe);
                        fail_tally++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d", want.status, status);
                        fail_tally++;
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    clpm_pkg::REG_NUM_STATES:    states_cfg = pwdata[15:0];
                    clpm_pkg::REG_NUM_PES:       pes_cfg = pwdata[15:0];
                    clpm_pkg::REG_PES_PER_GROUP: group_cfg = pwdata[15:0];
                    clpm_pkg::REG_NUM_PLANES:    planes_cfg = pwdata[8:0];
                    default:                     ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (req_type == clpm_pkg::REQ_LOAD)
                begin
                    if (plane_index < TABLE_DEPTH)
                    begin
                        weight_total = weight_total - plane_load[plane_index[7:0]] + weight;
                        plane_load[plane_index[7:0]] = weight;
                    end
                end
                else
                begin
                    pending_placements.push_back(place_object(state_index, plane_index));
                end
            end
        end
        open_queries <= pending_placements.size();
        mismatches <= fail_tally;
    end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS = 100;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic        req_type;
    logic [15:0] state_index;
    logic [15:0] plane_index;
    logic [15:0] weight;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] pe;
    logic [1:0]  status;

    int          open_queries;
    int          mismatches;
    int          load_count = 0;
    int          query_count = 0;
    int          setting_count = 0;
    int          quiet_cycles = 0;
    int          stall_left = 0;
    logic        idle_on = 1'b1;
    logic [15:0] cur_states = 16'd1;
    logic [8:0]  cur_planes = 9'd1;

    always #2 clk = ~clk;

    cumulative_load_plane_mapper DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .state_index (state_index),
        .plane_index (plane_index),
        .weight      (weight),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pe          (pe),
        .status      (status)
    );

    placement_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .state_index  (state_index),
        .plane_index  (plane_index),
        .weight       (weight),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pe           (pe),
        .status       (status),
        .open_queries (open_queries),
        .mismatches   (mismatches)
    );

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 18);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)
                || (psel && penable && pwrite && pready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic [15:0] ns, input logic [15:0] np,
                                 input logic [15:0] ppg, input logic [8:0] npl);
        write_reg(clpm_pkg::REG_NUM_STATES, {16'($urandom), ns});
        write_reg(clpm_pkg::REG_NUM_PES, {16'($urandom), np});
        write_reg(clpm_pkg::REG_PES_PER_GROUP, {16'($urandom), ppg});
        write_reg(clpm_pkg::REG_NUM_PLANES, {23'($urandom), npl});
        psel <= 1'b0;
        penable <= 1'b0;
        cur_states = ns;
        cur_planes = npl;
        setting_count++;
    endtask

    task automatic send_item(input logic req, input logic [15:0] s, input logic [15:0] p,
                             input logic [15:0] w);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        state_index <= s;
        plane_index <= p;
        weight <= w;
        do @(posedge clk); while (!in_ready);
        if (req == clpm_pkg::REQ_LOAD)
            load_count++;
        else
            query_count++;
    endtask

    // drain all queries, then let a trailing load write finish
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (open_queries != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic random_phase(input int items);
        int          k;
        int          used;
        int          span;
        logic [15:0] s;
        logic [15:0] p;
        logic [15:0] w;
        used = (cur_planes == 9'd0) ? 1 : ((cur_planes > 9'd256) ? 256 : int'(cur_planes));
        span = (cur_states == 16'd0) ? 1 : int'(cur_states);
        for (k = 0; k < items; k++)
        begin
            p = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, used - 1));
            if ($urandom_range(0, 99) < 35)
            begin
                if ($urandom_range(0, 7) == 0)
                    w = 16'd0;
                else if ($urandom_range(0, 7) == 0)
                    w = 16'hFFFF;
                else
                    w = 16'($urandom);
                send_item(clpm_pkg::REQ_LOAD, 16'($urandom), p, w);
            end
            else
            begin
                s = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, span - 1));
                send_item(clpm_pkg::REQ_QUERY, s, p, 16'($urandom));
            end
        end
    endtask

    initial
    begin : stimulus
        int          ph;
        logic [15:0] ns;
        logic [15:0] np;
        logic [15:0] ppg;
        logic [8:0]  npl;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= 4'd0;
        pwdata <= 32'd0;
        in_valid <= 1'b0;
        req_type <= clpm_pkg::REQ_LOAD;
        state_index <= 16'd0;
        plane_index <= 16'd0;
        weight <= 16'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        // hold off while the weight table clears
        repeat (clpm_pkg::TABLE_DEPTH_DEF + 20) @(posedge clk);

        apply_setting(16'd8, 16'd6, 16'd2, 9'd4);
        send_item(clpm_pkg::REQ_QUERY, 16'd3, 16'd1, 16'd0);
        send_item(clpm_pkg::REQ_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(clpm_pkg::REQ_QUERY, 16'd0, 16'd4, 16'd0);
        send_item(clpm_pkg::REQ_LOAD, 16'd0, 16'd0, 16'hFFFF);
        send_item(clpm_pkg::REQ_LOAD, 16'd0, 16'd1, 16'd0);
        send_item(clpm_pkg::REQ_LOAD, 16'd0, 16'd2, 16'd1);
        send_item(clpm_pkg::REQ_LOAD, 16'hFFFF, 16'd3, 16'h1234);
        send_item(clpm_pkg::REQ_LOAD, 16'd0, 16'd200, 16'd7);
        send_item(clpm_pkg::REQ_LOAD, 16'd0, 16'd256, 16'hFFFF);
        send_item(clpm_pkg::REQ_LOAD, 16'd0, 16'hFFFF, 16'hAAAA);
        send_item(clpm_pkg::REQ_QUERY, 16'd0, 16'd0, 16'd0);
        send_item(clpm_pkg::REQ_QUERY, 16'd7, 16'd3, 16'd0);
        send_item(clpm_pkg::REQ_QUERY, 16'd5, 16'd1, 16'd0);
        send_item(clpm_pkg::REQ_QUERY, 16'hFFFF, 16'd2, 16'd0);
        send_item(clpm_pkg::REQ_LOAD, 16'd0, 16'd0, 16'd0);
        send_item(clpm_pkg::REQ_QUERY, 16'd1, 16'd0, 16'd0);
        wait_idle();

        apply_setting(16'd0, 16'd0, 16'd0, 9'd3);
        send_item(clpm_pkg::REQ_QUERY, 16'h1234, 16'd2, 16'd0);
        send_item(clpm_pkg::REQ_QUERY, 16'hFFFF, 16'd3, 16'd0);
        wait_idle();

        apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 9'h1FF);
        send_item(clpm_pkg::REQ_QUERY, 16'hFFFF, 16'd255, 16'd0);
        send_item(clpm_pkg::REQ_QUERY, 16'd0, 16'd200, 16'd0);
        send_item(clpm_pkg::REQ_QUERY, 16'hFFFF, 16'd256, 16'd0);
        wait_idle();

        apply_setting(16'd1, 16'hFFFF, 16'd1, 9'd0);
        send_item(clpm_pkg::REQ_QUERY, 16'hFFFF, 16'd0, 16'd0);

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_idle();
            if (ph == RANDOM_PHASES - 1)
                idle_on = 1'b0;
            ns = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 40));
            np = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 48));
            ppg = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 12));
            npl = ($urandom_range(0, 4) == 0) ? 9'($urandom) : 9'($urandom_range(1, 24));
            apply_setting(ns, np, ppg, npl);
            random_phase(PHASE_ITEMS);
        end
        wait_idle();

        $display("covered %0d load writes and %0d placement queries under %0d register settings",
                 load_count, query_count, setting_count);
        $display("including zero load, hashed planes, zero and full-scale registers, idle bursts");
        if (mismatches == 0 && open_queries == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
